// ===== design/spo2_ratio_estimator_unit_macros.svh =====
// Assertion macros shared by the SpO2 estimator RTL.
`ifndef SPO2_RATIO_ESTIMATOR_UNIT_MACROS_SVH
`define SPO2_RATIO_ESTIMATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define SPO2E_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spo2e assertion failed");
// Next-cycle implication, disabled during reset.
`define SPO2E_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spo2e assertion failed");
`else
`define SPO2E_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define SPO2E_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/spo2e_pkg.sv =====
// Package: widths, register map, command codes and shared types of the SpO2 estimator.
`timescale 1ns / 1ps
package spo2e_pkg;

    localparam int IN_W    = 18;
    localparam int EXT_W   = 24;
    localparam int SPO2_W  = 7;
    localparam int THR_W   = 18;
    localparam int CNT_W   = 8;
    localparam int AVG_W   = 32;
    localparam int SUM_W   = 64;
    localparam int EST_W   = 24;
    localparam int MUL_W   = 34;
    localparam int PROD_W  = 68;
    localparam int RND_W   = 52;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;
    localparam int IT_W    = 7;

    localparam int MOD_STEPS = 8;
    localparam int SQ_STEPS  = 32;
    localparam int DIV_STEPS = 80;

    // Register map (index = paddr[3:2])
    localparam logic [1:0] REG_THR = 2'd0;
    localparam logic [1:0] REG_WL  = 2'd1;
    localparam logic [1:0] REG_PI  = 2'd2;

    localparam logic [THR_W-1:0] THR_RST = 18'd3000;
    localparam logic [CNT_W-1:0] WL_RST  = 8'd100;
    localparam logic [CNT_W-1:0] PI_RST  = 8'd5;

    localparam logic signed [EST_W-1:0] EST_RST = 24'sd24320;  // 95.0 in Q16.8
    localparam logic [SPO2_W-1:0] PUB_MAX = 7'd100;

    // Datapath actions
    typedef logic [4:0] t_act;
    localparam t_act A_NONE     = 5'd0;
    localparam t_act A_CAPTURE  = 5'd1;
    localparam t_act A_MOD_INIT = 5'd2;
    localparam t_act A_MOD_STEP = 5'd3;
    localparam t_act A_ACC_LOAD = 5'd4;
    localparam t_act A_RAVG     = 5'd5;
    localparam t_act A_IAVG     = 5'd6;
    localparam t_act A_MAG_R    = 5'd7;
    localparam t_act A_MAG_I    = 5'd8;
    localparam t_act A_RSUM     = 5'd9;
    localparam t_act A_ISUM     = 5'd10;
    localparam t_act A_PUB      = 5'd11;
    localparam t_act A_SQ_INIT  = 5'd12;
    localparam t_act A_SQ_STEP  = 5'd13;
    localparam t_act A_SQ_NEXT  = 5'd14;
    localparam t_act A_SQ_STORE = 5'd15;
    localparam t_act A_NUM_LOAD = 5'd16;
    localparam t_act A_DIV_INIT = 5'd17;
    localparam t_act A_DIV_STEP = 5'd18;
    localparam t_act A_RATIO    = 5'd19;
    localparam t_act A_RND_PROD = 5'd20;
    localparam t_act A_SPO2     = 5'd21;
    localparam t_act A_ACC_ADD  = 5'd22;
    localparam t_act A_RND_ACC  = 5'd23;
    localparam t_act A_EST_SAT  = 5'd24;
    localparam t_act A_CLEAR    = 5'd25;
    localparam t_act A_OUTPUT   = 5'd26;

    // Multiplier operand selects
    typedef logic [3:0] t_mul;
    localparam t_mul M_NONE = 4'd0;
    localparam t_mul M_RAVG = 4'd1;
    localparam t_mul M_RX   = 4'd2;
    localparam t_mul M_IAVG = 4'd3;
    localparam t_mul M_IX   = 4'd4;
    localparam t_mul M_MAG  = 4'd5;
    localparam t_mul M_NUM  = 4'd6;
    localparam t_mul M_DEN  = 4'd7;
    localparam t_mul M_DIFF = 4'd8;
    localparam t_mul M_EST  = 4'd9;
    localparam t_mul M_SPO2 = 4'd10;

    typedef struct packed {
        t_act act;
        t_mul mul;
    } t_cmd;

    typedef struct packed {
        logic win_end;
        logic div_ok;
        logic out_busy;
    } t_stat;

    typedef struct packed {
        logic [THR_W-1:0] thr;
        logic [CNT_W-1:0] wl;
        logic [CNT_W-1:0] pi;
    } t_cfg;

endpackage

// ===== design/spo2e_if.sv =====
// Interfaces: sample input channel and estimate output channel.
`timescale 1ns / 1ps
interface spo2e_in_if;
    import spo2e_pkg::*;
    logic              valid;
    logic              ready;
    logic [IN_W-1:0]   red_sample;
    logic [IN_W-1:0]   ir_sample;
    logic              boot_done;
    modport source (output valid, red_sample, ir_sample, boot_done, input ready);
    modport sink   (input valid, red_sample, ir_sample, boot_done, output ready);
endinterface

interface spo2e_out_if;
    import spo2e_pkg::*;
    logic              valid;
    logic              ready;
    logic [SPO2_W-1:0] spo2_percent;
    logic              window_done;
    modport source (output valid, spo2_percent, window_done, input ready);
    modport sink   (input valid, spo2_percent, window_done, output ready);
endinterface

// ===== design/spo2e_regs.sv =====
// APB configuration registers: finger threshold, window length, publish interval.
`timescale 1ns / 1ps
module spo2e_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [spo2e_pkg::ADDR_W-1:0] paddr,
    input  logic [spo2e_pkg::DATA_W-1:0] pwdata,
    output logic [spo2e_pkg::DATA_W-1:0] prdata,
    output logic                         pready,
    output spo2e_pkg::t_cfg              o_cfg
);
    import spo2e_pkg::*;

    logic [THR_W-1:0] r_thr;
    logic [CNT_W-1:0] r_wl;
    logic [CNT_W-1:0] r_pi;
    logic [1:0]       idx;
    logic             wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RST;
            r_wl  <= WL_RST;
            r_pi  <= PI_RST;
        end else if (wr_en) begin
            case (idx)
                REG_THR: r_thr <= pwdata[THR_W-1:0];
                REG_WL:  r_wl  <= pwdata[CNT_W-1:0];
                REG_PI:  r_pi  <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (idx)
            REG_THR: prdata = {{(DATA_W-THR_W){1'b0}}, r_thr};
            REG_WL:  prdata = {{(DATA_W-CNT_W){1'b0}}, r_wl};
            REG_PI:  prdata = {{(DATA_W-CNT_W){1'b0}}, r_pi};
            default: prdata = '0;
        endcase
    end

    assign o_cfg = '{thr: r_thr, wl: r_wl, pi: r_pi};

endmodule

// ===== design/spo2e_dp.sv =====
// Datapath: averages, deviation sums, root/divide units, estimate filter, output register.
`timescale 1ns / 1ps
`include "spo2_ratio_estimator_unit_macros.svh"
module spo2e_dp #(
    parameter int SAMPLE_BITS = 18
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  spo2e_pkg::t_cmd              i_cmd,
    input  spo2e_pkg::t_cfg              i_cfg,
    input  logic [spo2e_pkg::IN_W-1:0]   i_red_sample,
    input  logic [spo2e_pkg::IN_W-1:0]   i_ir_sample,
    input  logic                         i_boot_done,
    input  logic                         i_out_ready,
    output spo2e_pkg::t_stat             o_stat,
    output logic                         o_out_valid,
    output logic [spo2e_pkg::SPO2_W-1:0] o_spo2_percent,
    output logic                         o_window_done
);
    import spo2e_pkg::*;

    localparam int FRAC  = AVG_W - SAMPLE_BITS;
    localparam int SQ_SH = FRAC - 4;
    localparam int MAG_W = AVG_W - SQ_SH;

    // round half away from zero, drop 16 fraction bits
    function automatic logic signed [RND_W-1:0] f_rnd16(input logic signed [PROD_W-1:0] p);
        logic [PROD_W-1:0] m;
        logic [PROD_W-1:0] s;
        logic [RND_W-1:0]  q;
        m = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
        s = m + PROD_W'(32768);
        q = s[PROD_W-1:16];
        return p[PROD_W-1] ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [EST_W-1:0] f_sat24(input logic signed [RND_W:0] v);
        if (v > 53'sd8388607)
            return 24'sh7FFFFF;
        else if (v < -53'sd8388608)
            return 24'sh800000;
        else
            return v[EST_W-1:0];
    endfunction

    // model state
    logic [AVG_W-1:0]               r_ravg, r_iavg;
    logic [SUM_W-1:0]               r_rsum, r_isum;
    logic [CNT_W-1:0]               r_cnt;
    logic signed [EST_W-1:0]        r_est;
    logic [SPO2_W-1:0]              r_pub;
    logic                           r_ovalid, r_wdone;

    // working registers
    logic [SAMPLE_BITS-1:0]         r_red, r_ir;
    logic                           r_boot;
    logic [CNT_W-1:0]               r_mq, r_mrem;
    logic signed [PROD_W-1:0]       r_prod, r_acc;
    logic [MAG_W-1:0]               r_mag;
    logic [SUM_W-1:0]               r_sqv, r_sqres, r_sqbit;
    logic [AVG_W-1:0]               r_sqred, r_sqir;
    logic [SUM_W-1:0]               r_num, r_den, r_rem;
    logic [DIV_STEPS-1:0]           r_dq;
    logic signed [MUL_W-1:0]        r_diff;
    logic signed [RND_W-1:0]        r_rnd;
    logic signed [EST_W-1:0]        r_spo2;
    logic [SPO2_W-1:0]              r_ospo2;
    logic                           r_owdone;

    // input masking to the sample width
    logic [EXT_W-1:0]       red_ext, ir_ext;
    logic [SAMPLE_BITS-1:0] red_m, ir_m;
    assign red_ext = {{(EXT_W-IN_W){1'b0}}, i_red_sample};
    assign ir_ext  = {{(EXT_W-IN_W){1'b0}}, i_ir_sample};
    assign red_m   = red_ext[SAMPLE_BITS-1:0];
    assign ir_m    = ir_ext[SAMPLE_BITS-1:0];

    // samples aligned to the average's binary point
    logic [AVG_W-1:0] xs_red, xs_ir, dev_r, dev_i;
    assign xs_red = {r_red, {FRAC{1'b0}}};
    assign xs_ir  = {r_ir, {FRAC{1'b0}}};
    assign dev_r  = (xs_red >= r_ravg) ? xs_red - r_ravg : r_ravg - xs_red;
    assign dev_i  = (xs_ir >= r_iavg) ? xs_ir - r_iavg : r_iavg - xs_ir;

    // shared multiplier operands
    logic signed [MUL_W-1:0] ma, mb;
    always_comb begin
        ma = '0;
        mb = '0;
        case (i_cmd.mul)
            M_RAVG: begin ma = $signed({2'b00, r_ravg});  mb = 34'sd62259; end
            M_RX:   begin ma = $signed({2'b00, xs_red});  mb = 34'sd3277;  end
            M_IAVG: begin ma = $signed({2'b00, r_iavg});  mb = 34'sd62259; end
            M_IX:   begin ma = $signed({2'b00, xs_ir});   mb = 34'sd3277;  end
            M_MAG: begin
                ma = $signed({{(MUL_W-MAG_W){1'b0}}, r_mag});
                mb = $signed({{(MUL_W-MAG_W){1'b0}}, r_mag});
            end
            M_NUM:  begin ma = $signed({2'b00, r_sqred}); mb = $signed({2'b00, r_iavg}); end
            M_DEN:  begin ma = $signed({2'b00, r_sqir});  mb = $signed({2'b00, r_ravg}); end
            M_DIFF: begin ma = r_diff;                    mb = 34'sd5965;  end
            M_EST: begin
                ma = $signed({{(MUL_W-EST_W){r_est[EST_W-1]}}, r_est});
                mb = 34'sd45875;
            end
            M_SPO2: begin
                ma = $signed({{(MUL_W-EST_W){r_spo2[EST_W-1]}}, r_spo2});
                mb = 34'sd19661;
            end
            default: ;
        endcase
    end

    // average update sum
    logic signed [PROD_W-1:0] ema_sum;
    assign ema_sum = r_acc + r_prod + 68'sd32768;

    // saturating square-sum adds
    logic [SUM_W:0] rsum_add, isum_add;
    assign rsum_add = {1'b0, r_rsum} + {1'b0, r_prod[SUM_W-1:0]};
    assign isum_add = {1'b0, r_isum} + {1'b0, r_prod[SUM_W-1:0]};

    // publish interval remainder step (zero interval acts as one)
    logic [CNT_W-1:0] ival;
    logic [CNT_W:0]   mod_t;
    assign ival  = (i_cfg.pi == '0) ? CNT_W'(1) : i_cfg.pi;
    assign mod_t = {r_mrem, r_mq[CNT_W-1]};

    // root step
    logic [SUM_W-1:0] sq_trial;
    assign sq_trial = r_sqres + r_sqbit;

    // divide step
    logic [SUM_W:0] div_t, div_sub;
    logic           div_ge;
    assign div_t   = {r_rem, r_dq[DIV_STEPS-1]};
    assign div_sub = div_t - {1'b0, r_den};
    assign div_ge  = div_t >= {1'b0, r_den};

    // ratio with integer-part saturation
    logic [AVG_W-1:0] ratio_sat;
    assign ratio_sat = (|r_dq[DIV_STEPS-1:AVG_W]) ? '1 : r_dq[AVG_W-1:0];

    // publication
    logic                    pub_go;
    logic signed [EST_W-1:0] e_in, e_cl;
    assign pub_go = (r_mrem == '0) && r_boot;
    always_comb begin
        e_in = ({{(EXT_W-SAMPLE_BITS){1'b0}}, r_ir} < {{(EXT_W-THR_W){1'b0}}, i_cfg.thr})
               ? '0 : r_est;
        if (e_in <= -24'sd256)
            e_cl = '0;
        else if (e_in > 24'sd25600)
            e_cl = 24'sd25600;
        else
            e_cl = e_in;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ravg   <= '0;
            r_iavg   <= '0;
            r_rsum   <= '0;
            r_isum   <= '0;
            r_cnt    <= '0;
            r_est    <= EST_RST;
            r_pub    <= '0;
            r_ovalid <= 1'b0;
            r_wdone  <= 1'b0;
        end else begin
            if (i_cmd.act == A_OUTPUT)
                r_ovalid <= 1'b1;
            else if (i_out_ready)
                r_ovalid <= 1'b0;
            case (i_cmd.act)
                A_CAPTURE: begin
                    r_cnt   <= r_cnt + CNT_W'(1);
                    r_wdone <= 1'b0;
                end
                A_RAVG: r_ravg <= ema_sum[AVG_W+15:16];
                A_IAVG: r_iavg <= ema_sum[AVG_W+15:16];
                A_RSUM: r_rsum <= rsum_add[SUM_W] ? '1 : rsum_add[SUM_W-1:0];
                A_ISUM: r_isum <= isum_add[SUM_W] ? '1 : isum_add[SUM_W-1:0];
                A_PUB: begin
                    if (pub_go) begin
                        r_est <= e_cl;
                        r_pub <= (e_cl > 24'sd0) ? e_cl[14:8] : '0;
                    end
                end
                A_EST_SAT: r_est <= f_sat24($signed({r_rnd[RND_W-1], r_rnd}));
                A_CLEAR: begin
                    r_rsum  <= '0;
                    r_isum  <= '0;
                    r_cnt   <= '0;
                    r_wdone <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // working registers and multiplier
    always_ff @(posedge i_clk) begin
        r_prod <= ma * mb;
        case (i_cmd.act)
            A_CAPTURE: begin
                r_red  <= red_m;
                r_ir   <= ir_m;
                r_boot <= i_boot_done;
            end
            A_MOD_INIT: begin
                r_mq   <= r_cnt;
                r_mrem <= '0;
            end
            A_MOD_STEP: begin
                r_mq   <= {r_mq[CNT_W-2:0], 1'b0};
                r_mrem <= (mod_t >= {1'b0, ival}) ? CNT_W'(mod_t - {1'b0, ival})
                                                  : mod_t[CNT_W-1:0];
            end
            A_ACC_LOAD: r_acc <= r_prod;
            A_ACC_ADD:  r_acc <= r_acc + r_prod;
            A_MAG_R:    r_mag <= dev_r[AVG_W-1:SQ_SH];
            A_MAG_I:    r_mag <= dev_i[AVG_W-1:SQ_SH];
            A_SQ_INIT: begin
                r_sqv   <= r_rsum;
                r_sqres <= '0;
                r_sqbit <= SUM_W'(1) << 62;
            end
            A_SQ_STEP: begin
                if (r_sqv >= sq_trial) begin
                    r_sqv   <= r_sqv - sq_trial;
                    r_sqres <= (r_sqres >> 1) + r_sqbit;
                end else begin
                    r_sqres <= r_sqres >> 1;
                end
                r_sqbit <= r_sqbit >> 2;
            end
            A_SQ_NEXT: begin
                r_sqred <= r_sqres[AVG_W-1:0];
                r_sqv   <= r_isum;
                r_sqres <= '0;
                r_sqbit <= SUM_W'(1) << 62;
            end
            A_SQ_STORE: r_sqir <= r_sqres[AVG_W-1:0];
            A_NUM_LOAD: r_num  <= r_prod[SUM_W-1:0];
            A_DIV_INIT: begin
                r_den <= r_prod[SUM_W-1:0];
                r_rem <= '0;
                r_dq  <= {r_num, 16'b0};
            end
            A_DIV_STEP: begin
                r_rem <= div_ge ? div_sub[SUM_W-1:0] : div_t[SUM_W-1:0];
                r_dq  <= {r_dq[DIV_STEPS-2:0], div_ge};
            end
            A_RATIO:    r_diff <= $signed({2'b00, ratio_sat}) - 34'sd26214;
            A_RND_PROD: r_rnd  <= f_rnd16(r_prod);
            A_RND_ACC:  r_rnd  <= f_rnd16(r_acc);
            A_SPO2:     r_spo2 <= f_sat24(53'sd25600 - $signed({r_rnd[RND_W-1], r_rnd}));
            A_OUTPUT: begin
                r_ospo2  <= r_pub;
                r_owdone <= r_wdone;
            end
            default: ;
        endcase
    end

    // status to controller
    assign o_stat.win_end  = r_cnt >= i_cfg.wl;
    assign o_stat.div_ok   = (|r_ravg) && (|r_iavg) && (|r_isum);
    assign o_stat.out_busy = r_ovalid && !i_out_ready;

    assign o_out_valid    = r_ovalid;
    assign o_spo2_percent = r_ospo2;
    assign o_window_done  = r_owdone;

    `SPO2E_ASSERT_NEXT(a_pub_range, i_clk, i_rst_n, i_cmd.act == A_PUB, r_pub <= PUB_MAX)
    `SPO2E_ASSERT_IMPLY(a_sq_bit, i_clk, i_rst_n, i_cmd.act == A_SQ_STEP, $onehot0(r_sqbit))
    `SPO2E_ASSERT_IMPLY(a_div_rem, i_clk, i_rst_n, i_cmd.act == A_DIV_STEP, r_rem < r_den)

endmodule

// ===== design/spo2e_ctrl.sv =====
// Controller: sequences the datapath through one sample and, at window end, the ratio.
`timescale 1ns / 1ps
`include "spo2_ratio_estimator_unit_macros.svh"
module spo2e_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  spo2e_pkg::t_stat i_stat,
    output spo2e_pkg::t_cmd  o_cmd
);
    import spo2e_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_MOD_I = 5'd1;
    localparam logic [4:0] S_MOD   = 5'd2;
    localparam logic [4:0] S_RA1   = 5'd3;
    localparam logic [4:0] S_RA2   = 5'd4;
    localparam logic [4:0] S_RA3   = 5'd5;
    localparam logic [4:0] S_IA2   = 5'd6;
    localparam logic [4:0] S_IA3   = 5'd7;
    localparam logic [4:0] S_MAGR  = 5'd8;
    localparam logic [4:0] S_SQR   = 5'd9;
    localparam logic [4:0] S_SUMR  = 5'd10;
    localparam logic [4:0] S_SUMI  = 5'd11;
    localparam logic [4:0] S_PUB   = 5'd12;
    localparam logic [4:0] S_RT_I  = 5'd13;
    localparam logic [4:0] S_RT    = 5'd14;
    localparam logic [4:0] S_RT_N  = 5'd15;
    localparam logic [4:0] S_IT    = 5'd16;
    localparam logic [4:0] S_IT_S  = 5'd17;
    localparam logic [4:0] S_NUM   = 5'd18;
    localparam logic [4:0] S_DEN   = 5'd19;
    localparam logic [4:0] S_DVI   = 5'd20;
    localparam logic [4:0] S_DIV   = 5'd21;
    localparam logic [4:0] S_RFIX  = 5'd22;
    localparam logic [4:0] S_RMUL  = 5'd23;
    localparam logic [4:0] S_RRND  = 5'd24;
    localparam logic [4:0] S_SPO2  = 5'd25;
    localparam logic [4:0] S_F1    = 5'd26;
    localparam logic [4:0] S_F2    = 5'd27;
    localparam logic [4:0] S_F3    = 5'd28;
    localparam logic [4:0] S_F4    = 5'd29;
    localparam logic [4:0] S_CLR   = 5'd30;
    localparam logic [4:0] S_OUT   = 5'd31;

    logic [4:0]      r_state, n_state;
    logic [IT_W-1:0] r_it, n_it;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_it    <= '0;
        end else begin
            r_state <= n_state;
            r_it    <= n_it;
        end
    end

    // next state and command decode
    always_comb begin
        n_state    = r_state;
        n_it       = '0;
        o_cmd      = '{act: A_NONE, mul: M_NONE};
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.act = A_CAPTURE;
                    n_state   = S_MOD_I;
                end
            end
            S_MOD_I: begin o_cmd.act = A_MOD_INIT; n_state = S_MOD; end
            S_MOD: begin
                o_cmd.act = A_MOD_STEP;
                if (r_it == IT_W'(MOD_STEPS - 1)) n_state = S_RA1;
                else n_it = r_it + IT_W'(1);
            end
            // exponential averages
            S_RA1: begin o_cmd.mul = M_RAVG; n_state = S_RA2; end
            S_RA2: begin o_cmd.act = A_ACC_LOAD; o_cmd.mul = M_RX; n_state = S_RA3; end
            S_RA3: begin o_cmd.act = A_RAVG; o_cmd.mul = M_IAVG; n_state = S_IA2; end
            S_IA2: begin o_cmd.act = A_ACC_LOAD; o_cmd.mul = M_IX; n_state = S_IA3; end
            S_IA3: begin o_cmd.act = A_IAVG; n_state = S_MAGR; end
            // squared deviations
            S_MAGR: begin o_cmd.act = A_MAG_R; n_state = S_SQR; end
            S_SQR:  begin o_cmd.act = A_MAG_I; o_cmd.mul = M_MAG; n_state = S_SUMR; end
            S_SUMR: begin o_cmd.act = A_RSUM; o_cmd.mul = M_MAG; n_state = S_SUMI; end
            S_SUMI: begin o_cmd.act = A_ISUM; n_state = S_PUB; end
            S_PUB: begin
                o_cmd.act = A_PUB;
                if (!i_stat.win_end) n_state = S_OUT;
                else if (i_stat.div_ok) n_state = S_RT_I;
                else n_state = S_CLR;
            end
            // square roots
            S_RT_I: begin o_cmd.act = A_SQ_INIT; n_state = S_RT; end
            S_RT: begin
                o_cmd.act = A_SQ_STEP;
                if (r_it == IT_W'(SQ_STEPS - 1)) n_state = S_RT_N;
                else n_it = r_it + IT_W'(1);
            end
            S_RT_N: begin o_cmd.act = A_SQ_NEXT; n_state = S_IT; end
            S_IT: begin
                o_cmd.act = A_SQ_STEP;
                if (r_it == IT_W'(SQ_STEPS - 1)) n_state = S_IT_S;
                else n_it = r_it + IT_W'(1);
            end
            S_IT_S: begin o_cmd.act = A_SQ_STORE; n_state = S_NUM; end
            // ratio
            S_NUM: begin o_cmd.mul = M_NUM; n_state = S_DEN; end
            S_DEN: begin o_cmd.act = A_NUM_LOAD; o_cmd.mul = M_DEN; n_state = S_DVI; end
            S_DVI: begin o_cmd.act = A_DIV_INIT; n_state = S_DIV; end
            S_DIV: begin
                o_cmd.act = A_DIV_STEP;
                if (r_it == IT_W'(DIV_STEPS - 1)) n_state = S_RFIX;
                else n_it = r_it + IT_W'(1);
            end
            S_RFIX: begin o_cmd.act = A_RATIO; n_state = S_RMUL; end
            // SpO2 mapping and filter
            S_RMUL: begin o_cmd.mul = M_DIFF; n_state = S_RRND; end
            S_RRND: begin o_cmd.act = A_RND_PROD; n_state = S_SPO2; end
            S_SPO2: begin o_cmd.act = A_SPO2; o_cmd.mul = M_EST; n_state = S_F1; end
            S_F1:   begin o_cmd.act = A_ACC_LOAD; o_cmd.mul = M_SPO2; n_state = S_F2; end
            S_F2:   begin o_cmd.act = A_ACC_ADD; n_state = S_F3; end
            S_F3:   begin o_cmd.act = A_RND_ACC; n_state = S_F4; end
            S_F4:   begin o_cmd.act = A_EST_SAT; n_state = S_CLR; end
            S_CLR:  begin o_cmd.act = A_CLEAR; n_state = S_OUT; end
            S_OUT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.act = A_OUTPUT;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    `SPO2E_ASSERT_NEXT(a_accept_start, i_clk, i_rst_n, i_in_valid && r_state == S_IDLE, r_state == S_MOD_I)
    `SPO2E_ASSERT_IMPLY(a_loop_count, i_clk, i_rst_n, 1'b1, r_it < IT_W'(DIV_STEPS))
    `SPO2E_ASSERT_NEXT(a_out_free, i_clk, i_rst_n, r_state == S_OUT && !i_stat.out_busy, r_state == S_IDLE)

endmodule

// ===== design/spo2_ratio_estimator_unit.sv =====
// Top level of the ratio-of-ratios SpO2 estimator.
`timescale 1ns / 1ps
// One red/IR sample pair per item in, one result (last published SpO2, window flag) out.
// Items are processed one at a time by a controller sequencing a single shared 34x34
// multiplier: an ordinary sample runs the publish-interval remainder, then the averages
// and deviation sums, before the output register. A sample that closes a window also
// clears the window sums and, when a new estimate is computed, first runs two 32-step
// square roots and an 80-step shift-subtract divide, which dominate. The next item is
// accepted as soon as the result sits in the output register, even if not yet taken.
module spo2_ratio_estimator_unit #(
    parameter int SAMPLE_BITS = 18
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    spo2e_in_if.sink                     i_sample,
    spo2e_out_if.source                  o_result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [spo2e_pkg::ADDR_W-1:0] paddr,
    input  logic [spo2e_pkg::DATA_W-1:0] pwdata,
    output logic [spo2e_pkg::DATA_W-1:0] prdata,
    output logic                         pready
);
    import spo2e_pkg::*;

    t_cfg  cfg;
    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    spo2e_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    spo2e_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    spo2e_dp #(.SAMPLE_BITS(SAMPLE_BITS)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_cfg          (cfg),
        .i_red_sample   (i_sample.red_sample),
        .i_ir_sample    (i_sample.ir_sample),
        .i_boot_done    (i_sample.boot_done),
        .i_out_ready    (o_result.ready),
        .o_stat         (stat),
        .o_out_valid    (o_result.valid),
        .o_spo2_percent (o_result.spo2_percent),
        .o_window_done  (o_result.window_done)
    );

    assign i_sample.ready = in_ready;

endmodule
